/* rtl/vofs_pkg.sv */
// Shared types and constants for the vertex offset pipeline.
`default_nettype none
package vofs_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ThickBits = 24;
  localparam int unsigned MagBits   = 30;
  localparam int unsigned AbsBits   = 32;
  localparam int unsigned SqBits    = 2 * MagBits;
  localparam int unsigned SumBits   = SqBits + 2;
  localparam int unsigned LenBits   = 32;
  localparam int unsigned QuotBits  = ThickBits;
  localparam int unsigned NumBits   = MagBits + ThickBits;
  localparam int unsigned RemBits   = NumBits + 2;
  localparam int unsigned NormMsb   = 29;
  localparam int unsigned SqrtSteps = 31;

  // Short normal test: |n| < 1/1000 means sum * 10^6 < 2^(2*FracBits)
  localparam int unsigned SmallMagLimit = 128;
  localparam longint unsigned SmallSumLimit =
    ((64'd1 << (2 * FracBits)) + 64'd999999) / 64'd1000000;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [0:0] {
    RegWallThickness  = 1'b0,
    RegNormalsPresent = 1'b1
  } reg_idx_e;

  // Per-vertex data that rides alongside the arithmetic
  typedef struct packed {
    coord_t [2:0] pos;
    coord_t [2:0] nrm;
    logic [2:0]   neg;
    logic         near_zero;
    logic         last;
  } side_t;

endpackage
`default_nettype wire

/* rtl/vofs_front.sv */
// Front end: magnitudes, short-normal test, normalizing shift, squares and sum.
`default_nettype none
module vofs_front (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        en_i,
  input  wire                                        valid_i,
  input  wire                                        normals_present_i,
  input  vofs_pkg::coord_t [2:0]                     pos_i,
  input  vofs_pkg::coord_t [2:0]                     nrm_i,
  input  wire                                        last_i,
  output logic                                       valid_o,
  output vofs_pkg::side_t                            side_o,
  output logic [2:0][vofs_pkg::MagBits-1:0]          mag_o,
  output logic [vofs_pkg::SumBits-1:0]               sum_o
);

  // Stage 1 registers
  logic                                  v1_q;
  vofs_pkg::side_t                       side1_q, side1_d;
  logic [2:0][vofs_pkg::AbsBits-1:0]     mag1_q, mag1_d;
  // Stage 2 registers
  logic                                  v2_q;
  vofs_pkg::side_t                       side2_q, side2_d;
  logic [2:0][vofs_pkg::AbsBits-1:0]     mag2_q;
  logic [4:0]                            msb2_q, msb2_d;
  // Stage 3 registers
  logic                                  v3_q;
  vofs_pkg::side_t                       side3_q;
  logic [2:0][vofs_pkg::MagBits-1:0]     mag3_q, mag3_d;
  // Stage 4 registers
  logic                                  v4_q;
  vofs_pkg::side_t                       side4_q;
  logic [2:0][vofs_pkg::MagBits-1:0]     mag4_q;
  logic [2:0][vofs_pkg::SqBits-1:0]      sq4_q, sq4_d;
  // Stage 5 registers
  logic                                  v5_q;
  vofs_pkg::side_t                       side5_q;
  logic [2:0][vofs_pkg::MagBits-1:0]     mag5_q;
  logic [vofs_pkg::SumBits-1:0]          sum5_q, sum5_d;

  // Stage 1: mask absent normals, split sign and magnitude
  always_comb begin
    vofs_pkg::coord_t n;
    side1_d       = '0;
    side1_d.pos   = pos_i;
    side1_d.last  = last_i;
    for (int i = 0; i < 3; i++) begin
      n               = normals_present_i ? nrm_i[i] : '0;
      side1_d.nrm[i]  = n;
      side1_d.neg[i]  = n[vofs_pkg::CoordBits-1];
      mag1_d[i]       = n[vofs_pkg::CoordBits-1] ? vofs_pkg::AbsBits'(-n)
                                                 : vofs_pkg::AbsBits'(n);
    end
  end

  // Stage 2: largest magnitude, its leading bit, short-normal test
  always_comb begin
    logic [vofs_pkg::AbsBits-1:0] m;
    logic [15:0]                  ssum;
    m = mag1_q[0];
    if (mag1_q[1] > m) m = mag1_q[1];
    if (mag1_q[2] > m) m = mag1_q[2];
    msb2_d = '0;
    for (int b = 0; b < vofs_pkg::AbsBits; b++) begin
      if (m[b]) msb2_d = 5'(b);
    end
    ssum = '0;
    for (int i = 0; i < 3; i++) begin
      ssum = ssum + 16'(mag1_q[i][6:0] * mag1_q[i][6:0]);
    end
    side2_d           = side1_q;
    side2_d.near_zero = (m < vofs_pkg::AbsBits'(vofs_pkg::SmallMagLimit)) &&
                        (ssum < 16'(vofs_pkg::SmallSumLimit));
  end

  // Stage 3: shift so the largest magnitude lands in [2^29, 2^30); short normals pass unshifted
  always_comb begin
    logic [60:0] w;
    for (int i = 0; i < 3; i++) begin
      w         = (61'(mag2_q[i]) << vofs_pkg::NormMsb) >> msb2_q;
      mag3_d[i] = side2_q.near_zero ? mag2_q[i][vofs_pkg::MagBits-1:0]
                                    : w[vofs_pkg::MagBits-1:0];
    end
  end

  // Stage 4: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = mag3_q[i] * mag3_q[i];
    end
  end

  // Stage 5: sum of squares
  assign sum5_d = vofs_pkg::SumBits'(sq4_q[0]) + vofs_pkg::SumBits'(sq4_q[1]) +
                  vofs_pkg::SumBits'(sq4_q[2]);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      mag1_q  <= mag1_d;
      side2_q <= side2_d;
      mag2_q  <= mag1_q;
      msb2_q  <= msb2_d;
      side3_q <= side2_q;
      mag3_q  <= mag3_d;
      side4_q <= side3_q;
      mag4_q  <= mag3_q;
      sq4_q   <= sq4_d;
      side5_q <= side4_q;
      mag5_q  <= mag4_q;
      sum5_q  <= sum5_d;
    end
  end

  assign valid_o = v5_q;
  assign side_o  = side5_q;
  assign mag_o   = mag5_q;
  assign sum_o   = sum5_q;

endmodule
`default_nettype wire

/* rtl/vofs_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vofs_isqrt (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        en_i,
  input  wire                                        valid_i,
  input  vofs_pkg::side_t                            side_i,
  input  wire  [2:0][vofs_pkg::MagBits-1:0]          mag_i,
  input  wire  [vofs_pkg::SumBits-1:0]               sum_i,
  output logic                                       valid_o,
  output vofs_pkg::side_t                            side_o,
  output logic [2:0][vofs_pkg::MagBits-1:0]          mag_o,
  output logic [vofs_pkg::LenBits-1:0]               len_o
);

  localparam int unsigned N = vofs_pkg::SqrtSteps;

  logic                                  v_q    [N];
  vofs_pkg::side_t                       side_q [N];
  logic [2:0][vofs_pkg::MagBits-1:0]     mag_q  [N];
  logic [63:0]                           x_q    [N];
  logic [63:0]                           r_q    [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (N - 1 - s));
    logic                              pv;
    vofs_pkg::side_t                   pside;
    logic [2:0][vofs_pkg::MagBits-1:0] pmag;
    logic [63:0]                       px, pr, x_d, r_d;

    if (s == 0) begin : g_head
      assign pv    = valid_i;
      assign pside = side_i;
      assign pmag  = mag_i;
      assign px    = 64'(sum_i);
      assign pr    = '0;
    end else begin : g_body
      assign pv    = v_q[s-1];
      assign pside = side_q[s-1];
      assign pmag  = mag_q[s-1];
      assign px    = x_q[s-1];
      assign pr    = r_q[s-1];
    end

    // Try the next root bit; keep it if the remainder allows
    always_comb begin
      if (px >= pr + Bit) begin
        x_d = px - (pr + Bit);
        r_d = (pr >> 1) + Bit;
      end else begin
        x_d = px;
        r_d = pr >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= pside;
        mag_q[s]  <= pmag;
        x_q[s]    <= x_d;
        r_q[s]    <= r_d;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign mag_o   = mag_q[N-1];
  assign len_o   = r_q[N-1][vofs_pkg::LenBits-1:0];

endmodule
`default_nettype wire

/* rtl/vofs_div.sv */
// Scale by thickness, then pipelined restoring divide by the normal length.
`default_nettype none
module vofs_div (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        en_i,
  input  wire                                        valid_i,
  input  vofs_pkg::side_t                            side_i,
  input  wire  [2:0][vofs_pkg::MagBits-1:0]          mag_i,
  input  wire  [vofs_pkg::LenBits-1:0]               len_i,
  input  wire  [vofs_pkg::ThickBits-1:0]             thick_i,
  output logic                                       valid_o,
  output vofs_pkg::side_t                            side_o,
  output logic [2:0][vofs_pkg::QuotBits-1:0]         quot_o
);

  localparam int unsigned N = vofs_pkg::QuotBits;

  // Product stage
  logic                                  vm_q;
  vofs_pkg::side_t                       sidem_q;
  logic [2:0][vofs_pkg::RemBits-1:0]     numm_q, numm_d;
  logic [vofs_pkg::LenBits-1:0]          denm_q, denm_d;

  // Quotient stages
  logic                                  v_q    [N];
  vofs_pkg::side_t                       side_q [N];
  logic [2:0][vofs_pkg::RemBits-1:0]     rem_q  [N];
  logic [2:0][vofs_pkg::QuotBits-1:0]    quo_q  [N];
  logic [vofs_pkg::LenBits-1:0]          den_q  [N];

  // Short normals divide by 1.0, which is the plain fraction shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numm_d[i] = vofs_pkg::RemBits'(mag_i[i] * thick_i);
    end
    denm_d = side_i.near_zero ? vofs_pkg::LenBits'(1) << vofs_pkg::FracBits : len_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sidem_q <= side_i;
      numm_q  <= numm_d;
      denm_q  <= denm_d;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam int unsigned Sh = N - 1 - s;
    logic                                 pv;
    vofs_pkg::side_t                      pside;
    logic [2:0][vofs_pkg::RemBits-1:0]    prem, rem_d;
    logic [2:0][vofs_pkg::QuotBits-1:0]   pquo, quo_d;
    logic [vofs_pkg::LenBits-1:0]         pden;
    logic [vofs_pkg::RemBits-1:0]         trial;

    if (s == 0) begin : g_head
      assign pv    = vm_q;
      assign pside = sidem_q;
      assign prem  = numm_q;
      assign pquo  = '0;
      assign pden  = denm_q;
    end else begin : g_body
      assign pv    = v_q[s-1];
      assign pside = side_q[s-1];
      assign prem  = rem_q[s-1];
      assign pquo  = quo_q[s-1];
      assign pden  = den_q[s-1];
    end

    // Subtract the shifted divisor where it fits, set that quotient bit
    always_comb begin
      trial = vofs_pkg::RemBits'(pden) << Sh;
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = prem[i];
        quo_d[i] = pquo[i];
        if (prem[i] >= trial) begin
          rem_d[i]     = prem[i] - trial;
          quo_d[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= pside;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= pden;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign quot_o  = quo_q[N-1];

endmodule
`default_nettype wire

/* rtl/vertex_offset_along_normal.sv */
// Top level: configuration registers, pipeline, offset add with saturation.
`default_nettype none
// Moves each vertex inward along its normalized normal by the wall thickness:
// offset = pos - n/|n| * t, saturated to 32 bits, normal and last flag passed
// through. A fully pipelined datapath takes one vertex per clock while the
// output is not stalled; each vertex passes through 5 front-end stages for
// magnitude, normalizing shift and squares, 31 square-root stages, 25
// scale-and-divide stages and one output stage. The whole pipeline holds when
// the output transfer stalls, so in_ready_o follows out_ready_i while a result
// is waiting. Write configuration only when no vertex is in flight.
module vertex_offset_along_normal (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire  [vofs_pkg::ThickBits-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  signed [31:0]               pos_x_i,
  input  wire  signed [31:0]               pos_y_i,
  input  wire  signed [31:0]               pos_z_i,
  input  wire  signed [31:0]               normal_x_i,
  input  wire  signed [31:0]               normal_y_i,
  input  wire  signed [31:0]               normal_z_i,
  input  wire                              last_vertex_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [31:0]               offset_x_o,
  output logic signed [31:0]               offset_y_o,
  output logic signed [31:0]               offset_z_o,
  output logic signed [31:0]               out_normal_x_o,
  output logic signed [31:0]               out_normal_y_o,
  output logic signed [31:0]               out_normal_z_o,
  output logic                             last_out_o
);

  logic [vofs_pkg::ThickBits-1:0]          wall_q;
  logic                                    nrm_en_q;
  logic                                    en;

  logic                                    f_valid;
  vofs_pkg::side_t                         f_side;
  logic [2:0][vofs_pkg::MagBits-1:0]       f_mag;
  logic [vofs_pkg::SumBits-1:0]            f_sum;

  logic                                    s_valid;
  vofs_pkg::side_t                         s_side;
  logic [2:0][vofs_pkg::MagBits-1:0]       s_mag;
  logic [vofs_pkg::LenBits-1:0]            s_len;

  logic                                    d_valid;
  vofs_pkg::side_t                         d_side;
  logic [2:0][vofs_pkg::QuotBits-1:0]      d_quot;

  logic                                    out_valid_q;
  vofs_pkg::coord_t [2:0]                  off_q, off_d;
  vofs_pkg::coord_t [2:0]                  onrm_q;
  logic                                    last_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q   <= vofs_pkg::ThickBits'(65536);
      nrm_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (vofs_pkg::reg_idx_e'(cfg_idx_i))
        vofs_pkg::RegWallThickness:  wall_q   <= cfg_wdata_i;
        vofs_pkg::RegNormalsPresent: nrm_en_q <= cfg_wdata_i[0];
        default:                     wall_q   <= wall_q;
      endcase
    end
  end

  // Hold the whole pipeline while a result waits for its transfer
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  vofs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .normals_present_i (nrm_en_q),
    .pos_i             ({pos_z_i, pos_y_i, pos_x_i}),
    .nrm_i             ({normal_z_i, normal_y_i, normal_x_i}),
    .last_i            (last_vertex_i),
    .valid_o           (f_valid),
    .side_o            (f_side),
    .mag_o             (f_mag),
    .sum_o             (f_sum)
  );

  vofs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .mag_i   (f_mag),
    .sum_i   (f_sum),
    .valid_o (s_valid),
    .side_o  (s_side),
    .mag_o   (s_mag),
    .len_o   (s_len)
  );

  vofs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .mag_i   (s_mag),
    .len_i   (s_len),
    .thick_i (wall_q),
    .valid_o (d_valid),
    .side_o  (d_side),
    .quot_o  (d_quot)
  );

  // Apply the offset against the normal's sign and saturate
  always_comb begin
    logic signed [33:0] r;
    for (int i = 0; i < 3; i++) begin
      if (d_side.neg[i]) begin
        r = 34'(d_side.pos[i]) + $signed({10'b0, d_quot[i]});
      end else begin
        r = 34'(d_side.pos[i]) - $signed({10'b0, d_quot[i]});
      end
      if (r[33:31] == 3'b000 || r[33:31] == 3'b111) begin
        off_d[i] = r[31:0];
      end else if (r[33]) begin
        off_d[i] = {1'b1, 31'b0};
      end else begin
        off_d[i] = {1'b0, {31{1'b1}}};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      off_q  <= off_d;
      onrm_q <= d_side.nrm;
      last_q <= d_side.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign offset_x_o     = off_q[0];
  assign offset_y_o     = off_q[1];
  assign offset_z_o     = off_q[2];
  assign out_normal_x_o = onrm_q[0];
  assign out_normal_y_o = onrm_q[1];
  assign out_normal_z_o = onrm_q[2];
  assign last_out_o     = last_q;

  // A waiting result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // The normalized largest magnitude has its top bit set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !f_side.near_zero |-> (f_mag[0][29] || f_mag[1][29] || f_mag[2][29]))
    else $error("normalizing shift out of range");

  // Normal length lands in [2^29, 2^31) for a full-size normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid && !s_side.near_zero |-> (s_len[31:29] != 3'b000) && !s_len[31])
    else $error("square root out of range");

endmodule
`default_nettype wire

/* dv/tb_vertex_offset_along_normal.sv */
// Testbench for inward vertex offset pipeline: directed, config sweep, backpressure, random.
`default_nettype none
module tb_vertex_offset_along_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned LongHold    = 300;

  typedef struct packed {
    vofs_pkg::coord_t [2:0] pos;
    vofs_pkg::coord_t [2:0] nrm;
    logic                   last;
  } vertex_t;

  typedef struct packed {
    vofs_pkg::coord_t [2:0] ofs;
    vofs_pkg::coord_t [2:0] nrm;
    logic                   last;
  } shifted_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [vofs_pkg::ThickBits-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vertex_t drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  vofs_pkg::coord_t ofs_x, ofs_y, ofs_z, onx, ony, onz;
  logic last_out_o;

  // Predictor copies of the registers
  logic [vofs_pkg::ThickBits-1:0] thickness = 24'd65536;
  logic                           nrm_on = 1'b1;

  shifted_t  expected_q[$];
  int        mismatches = 0;
  int        checked = 0;
  int        sent = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  bit        hold_req = 1'b0;
  longint    cycles = 0;

  vertex_offset_along_normal u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .pos_x_i(drv.pos[0]), .pos_y_i(drv.pos[1]), .pos_z_i(drv.pos[2]),
    .normal_x_i(drv.nrm[0]), .normal_y_i(drv.nrm[1]), .normal_z_i(drv.nrm[2]),
    .last_vertex_i(drv.last),
    .out_valid_o, .out_ready_i,
    .offset_x_o(ofs_x), .offset_y_o(ofs_y), .offset_z_o(ofs_z),
    .out_normal_x_o(onx), .out_normal_y_o(ony), .out_normal_z_o(onz),
    .last_out_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("[vertex_offset_along_normal] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected offset position for one vertex under the current registers
  function automatic shifted_t offset_vertex(vertex_t v);
    shifted_t        res;
    longint          n[3];
    longint          r;
    longint unsigned mag[3], term[3];
    longint unsigned m, sum, len, t;
    int              lsh, rsh;
    m = 0;
    sum = 0;
    t = thickness;
    for (int i = 0; i < 3; i++) begin
      n[i] = nrm_on ? longint'(v.nrm[i]) : 0;
      mag[i] = n[i] < 0 ? longint'(-n[i]) : n[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m < (64'd1 << 15))
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    if (m < (64'd1 << 15) &&
        sum * 64'd1000000 < (64'd1 << (2 * vofs_pkg::FracBits))) begin
      for (int i = 0; i < 3; i++) term[i] = (mag[i] * t) >> vofs_pkg::FracBits;
    end else begin
      lsh = 0;
      rsh = 0;
      while (m < (64'd1 << 29)) begin m <<= 1; lsh++; end
      while (m >= (64'd1 << 30)) begin m >>= 1; rsh++; end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (mag[i] << lsh) >> rsh;
        sum += mag[i] * mag[i];
      end
      len = int_sqrt(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) term[i] = (mag[i] * t) / len;
    end
    for (int i = 0; i < 3; i++) begin
      r = n[i] < 0 ? longint'(v.pos[i]) + longint'(term[i])
                   : longint'(v.pos[i]) - longint'(term[i]);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.ofs[i] = r[31:0];
      res.nrm[i] = n[i][31:0];
    end
    res.last = v.last;
    return res;
  endfunction

  // Compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    shifted_t got, exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.ofs = {ofs_z, ofs_y, ofs_x};
      got.nrm = {onz, ony, onx};
      got.last = last_out_o;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch #%0d ofs exp %0d %0d %0d got %0d %0d %0d",
                     checked, exp_r.ofs[0], exp_r.ofs[1], exp_r.ofs[2],
                     got.ofs[0], got.ofs[1], got.ofs[2]);
            $display("  nrm exp %0d %0d %0d got %0d %0d %0d | last exp %0b got %0b",
                     exp_r.nrm[0], exp_r.nrm[1], exp_r.nrm[2],
                     got.nrm[0], got.nrm[1], got.nrm[2], exp_r.last, got.last);
          end
        end
      end
    end
  end

  // Output ready: stretches of full rate, random stalls, and a long hold on request
  initial begin
    int mode, span;
    forever begin
      if (hold_req) begin
        @(negedge clk_i) out_ready_i = 1'b0;
        for (int c = 0; c < LongHold; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 40);
      for (int c = 0; c < span && !hold_req; c++) begin
        @(negedge clk_i);
        unique case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(0, 3) != 0);
          default: out_ready_i = ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Offer one vertex and hold it until the transfer
  task automatic send_vertex(vertex_t v);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk_i) in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end else begin
      @(negedge clk_i);
    end
    drv = v;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(offset_vertex(v));
    sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk_i) in_valid_i = 1'b0;
    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(vofs_pkg::reg_idx_e idx, logic [vofs_pkg::ThickBits-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i) cfg_we_i = 1'b0;
    if (idx == vofs_pkg::RegWallThickness) thickness = val;
    else nrm_on = val[0];
  endtask

  function automatic vofs_pkg::coord_t rand_coord();
    unique case ($urandom_range(0, 6))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(0, 160)) - 80);
      3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    for (int i = 0; i < 3; i++) begin
      v.pos[i] = rand_coord();
      v.nrm[i] = rand_coord();
    end
    v.last = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  function automatic vertex_t mk(vofs_pkg::coord_t px, vofs_pkg::coord_t py,
                                 vofs_pkg::coord_t pz, vofs_pkg::coord_t nx,
                                 vofs_pkg::coord_t ny, vofs_pkg::coord_t nz, logic lst);
    vertex_t v;
    v.pos = {pz, py, px};
    v.nrm = {nz, ny, nx};
    v.last = lst;
    return v;
  endfunction

  // Extremes, zero and short normals around the 1/1000 threshold, saturation
  task automatic test_directed();
    send_vertex(mk(0, 0, 0, 0, 0, 0, 1'b0));
    send_vertex(mk(100, -100, 5, 32'sh10000, 0, 0, 1'b1));
    send_vertex(mk(1, 2, 3, 65, 0, 0, 1'b0));
    send_vertex(mk(1, 2, 3, 66, 0, 0, 1'b0));
    send_vertex(mk(7, 7, 7, -37, 37, -37, 1'b0));
    send_vertex(mk(7, 7, 7, 38, -38, 38, 1'b1));
    send_vertex(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 1, 1'b0));
    send_vertex(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -1, -1, -1, 1'b0));
    send_vertex(mk(32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh80000000, 32'sh80000000,
                   32'sh80000000, 1'b0));
    send_vertex(mk(0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1));
    send_vertex(mk(-1, -1, -1, 0, 0, 32'sh80000000, 1'b0));
    send_vertex(mk(5, 5, 5, 3, 4, 0, 1'b0));
    send_vertex(mk(32'h12345678, 32'hFEDCBA98, 32'h0F0F0F0F, 32'hAAAAAAAA, 32'h55555555,
                   32'h00010000, 1'b1));
  endtask

  // Thickness extremes and normals switched off, then restored
  task automatic test_config_sweep();
    logic [vofs_pkg::ThickBits-1:0] vals[4];
    vals = '{24'd1, 24'hFFFFFF, 24'd1000, 24'd65536};
    foreach (vals[k]) begin
      write_reg(vofs_pkg::RegWallThickness, vals[k]);
      test_directed();
      repeat (15) send_vertex(rand_vertex());
    end
    write_reg(vofs_pkg::RegNormalsPresent, 24'd0);
    test_directed();
    repeat (20) send_vertex(rand_vertex());
    write_reg(vofs_pkg::RegNormalsPresent, 24'd1);
  endtask

  // Receiver holds off long while the sender keeps offering back to back
  task automatic test_backpressure();
    wait_idle();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (120) send_vertex(rand_vertex());
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random();
    for (int k = 0; k < 400; k++) begin
      if (k % 100 == 50)
        write_reg(vofs_pkg::RegWallThickness, 24'($urandom_range(1, 24'hFFFFFF)));
      gaps_on = (k % 160) < 110;
      send_vertex(rand_vertex());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_idle();
    $display("covered %0d vertices: thickness extremes, normals on and off,",
             sent);
    $display("short and full-range normals, saturation, long output stalls; %0d checked",
             checked);
    if (mismatches == 0) begin
      $display("[vertex_offset_along_normal] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[vertex_offset_along_normal] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
